// ===== hdl/sha256_byte_stream_hasher_core_defines.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
    localparam int BlockBytes = 64;
    localparam int Rounds = 64;
    localparam int DigestWords = 8;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rnd_ctl_t;

    localparam word_t INIT_HASH [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic word_t ror(input word_t v, input int s);
        ror = (v >> s) | (v << (32 - s));
    endfunction
endpackage
`default_nettype wire

// ===== hdl/sha_round.sv =====
// One shared SHA-256 round unit with rolling message schedule, 64 iterations.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_core_defines.svh"
module sha_round (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sha_pkg::rnd_ctl_t ctl_in,
    input  wire logic [511:0]    block,
    input  wire logic [255:0]    hash_in,
    output sha_pkg::rnd_ctl_t    ctl_out,
    output logic [255:0]         vars
);
    import sha_pkg::*;

    word_t w_reg [16];
    word_t v_reg [8];
    logic [5:0] rnd_reg;
    logic busy_reg, done_reg;
    word_t wt, w_new, s0, s1, b1, ch, mj, b0, t1, t2;

    always_comb
    begin
        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        // w[i+16] from the window holding w[i..i+15]
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        wt = w_reg[0];
        b1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + b1 + ch + ROUND_K[rnd_reg] + wt;
        b0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = b0 + mj;
    end

    // window shifts each round; slot 0 always holds w[i]
    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= block[511 - 32 * i -: 32];
            for (int j = 0; j < 8; j++)
                v_reg[j] <= hash_in[255 - 32 * j -: 32];
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'(Rounds - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        ctl_out.start = ctl_in.start;
        ctl_out.busy = busy_reg;
        ctl_out.done = done_reg;
        for (int j = 0; j < 8; j++)
            vars[255 - 32 * j -: 32] = v_reg[j];
    end

    `SHA_ASSERT_NXT(a_done_ends, clk, rst_n, done_reg, !busy_reg)
    `SHA_ASSERT_IMP(a_no_overlap, clk, rst_n, done_reg, !(busy_reg && rnd_reg != 6'd0))
    `SHA_ASSERT_NXT(a_start_busy, clk, rst_n, ctl_in.start, busy_reg && rnd_reg == 6'd0)
endmodule
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher_core.sv =====
// Top level: byte-stream SHA-256 hasher with a shared iterative round unit.
//
//  channel | dir | handshake         | fields
//  in      | in  | in_valid/in_stall | data_byte, byte_present, end_of_message
//  out     | out | out_valid/out_stall | digest_word, word_index, final_word
//
// Bytes are taken one per cycle while a block fills; a full block stalls the
// input through load, the 64 rounds of the single round unit, the done flag
// and the chain update.
// A final word adds padding, one or two compressions and eight output words,
// each held until taken. Reset is asynchronous, active low; the chaining
// value returns to the initial hash.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_core_defines.svh"
module sha256_byte_stream_hasher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             final_word
);
    import sha_pkg::*;

    state_t state_reg, state_next;
    word_t buf_reg [BlockBytes / 4];   // block bytes, big-endian within each word
    logic [5:0] fill_reg;
    logic [63:0] bits_reg;
    word_t hash_reg [DigestWords];
    logic last_reg;           // final block of message pending
    logic pad_done_reg;       // 0x80 already placed
    logic [2:0] idx_reg;
    logic [511:0] blk;
    logic [255:0] hin, vars;
    rnd_ctl_t rin, rout;
    logic acc;

    assign acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_FILL);

    always_comb
    begin
        for (int i = 0; i < BlockBytes / 4; i++)
            blk[511 - 32 * i -: 32] = buf_reg[i];
        for (int j = 0; j < DigestWords; j++)
            hin[255 - 32 * j -: 32] = hash_reg[j];
        rin.start = (state_reg == ST_LOAD);
        rin.busy = 1'b0;
        rin.done = 1'b0;
    end

    sha_round u_round (
        .clk(clk), .rst_n(rst_n), .ctl_in(rin), .block(blk),
        .hash_in(hin), .ctl_out(rout), .vars(vars)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
                if (acc)
                begin
                    if (byte_present && fill_reg == 6'd63)
                        state_next = ST_LOAD;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            ST_PAD:
                // pad one byte per cycle; length fits once 0x80 in and fill reaches 56
                if (pad_done_reg && fill_reg == LEN_POS)
                    state_next = ST_LOAD;
                else if (fill_reg == 6'd63)
                    state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_ROUND;
            ST_ROUND:  if (rout.done) state_next = ST_UPDATE;
            ST_UPDATE:
                if (!last_reg)
                    state_next = ST_FILL;
                else if (fill_reg == LEN_POS)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            ST_EMIT:
                if (!out_stall && idx_reg == 3'd7)
                    state_next = ST_FILL;
            default:   state_next = ST_FILL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL && acc && byte_present)
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= data_byte;
        else if (state_reg == ST_PAD)
        begin
            if (pad_done_reg && fill_reg == LEN_POS)
            begin
                buf_reg[LEN_POS[5:2]] <= bits_reg[63:32];
                buf_reg[LEN_POS[5:2] + 4'd1] <= bits_reg[31:0];
            end
            else
                buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <=
                    pad_done_reg ? 8'h00 : PAD_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg <= '0;
            bits_reg <= '0;
            last_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            idx_reg <= '0;
            for (int j = 0; j < DigestWords; j++)
                hash_reg[j] <= INIT_HASH[j];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_FILL:
                    if (acc)
                    begin
                        if (byte_present)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                        last_reg <= end_of_message;
                    end
                ST_PAD:
                    if (!(pad_done_reg && fill_reg == LEN_POS))
                    begin
                        pad_done_reg <= 1'b1;
                        fill_reg <= fill_reg + 6'd1;
                    end
                ST_UPDATE:
                begin
                    for (int j = 0; j < DigestWords; j++)
                        hash_reg[j] <= hash_reg[j] + vars[255 - 32 * j -: 32];
                end
                ST_EMIT:
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int j = 0; j < DigestWords; j++)
                                hash_reg[j] <= INIT_HASH[j];
                            fill_reg <= '0;
                            bits_reg <= '0;
                            last_reg <= 1'b0;
                            pad_done_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = hash_reg[idx_reg];
    assign word_index = idx_reg;
    assign final_word = (idx_reg == 3'd7);

    `SHA_ASSERT_IMP(a_emit_idle_round, clk, rst_n, out_valid, !rout.busy)
    `SHA_ASSERT_IMP(a_stall_fill, clk, rst_n, state_reg == ST_ROUND, in_stall && !out_valid)
    `SHA_ASSERT_NXT(a_last_wrap, clk, rst_n, out_valid && !out_stall && final_word,
                    fill_reg == 6'd0 && bits_reg == 64'd0)
endmodule
`default_nettype wire

// ===== tb/tb_sha256_byte_stream_hasher_core.sv =====
// Testbench for the byte-stream SHA-256 hasher: directed and random messages.
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_byte_stream_hasher_core;
    import sha_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    sha256_byte_stream_hasher_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .final_word     (final_word)
    );

    // One expected digest word as the block should emit it.
    typedef struct {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // One input word; has_exp marks rows with a typed-in digest.
    typedef struct {
        logic [7:0]   byte_val;
        logic         present;
        logic         eom;
        bit           has_exp;
        logic [255:0] exp_digest;
    } stim_row_t;

    digest_word_t digest_q[$];
    logic [255:0] typed_digest_q[$];

    // Predictor state: chaining value, pending block bytes, bit count.
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    int          fill;
    logic [63:0] msg_bits;

    int  mismatches = 0;
    bit  timed_out = 0;
    bit  idle_off = 0;
    bit  hold_rx = 0;
    int  inputs_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    // Standard 64-round compression of blk into chain.
    task automatic compress_blk();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic restart_msg();
        for (int i = 0; i < 8; i++)
            chain[i] = INIT_HASH[i];
        fill = 0;
        msg_bits = '0;
    endtask

    // Feed one accepted word to the predictor; queue eight digest words on end.
    task automatic predict_digest(logic [7:0] b, logic present, logic eom);
        digest_word_t dw;
        if (present)
        begin
            blk[fill] = b;
            fill++;
            msg_bits += 64'd8;
            if (fill == 64)
            begin
                compress_blk();
                fill = 0;
            end
        end
        if (!eom)
            return;
        blk[fill] = PAD_BYTE;
        fill++;
        if (fill > 56)
        begin
            for (int i = fill; i < 64; i++)
                blk[i] = 8'h00;
            compress_blk();
            fill = 0;
        end
        for (int i = fill; i < 56; i++)
            blk[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk[56+i] = msg_bits[63-8*i -: 8];
        compress_blk();
        for (int i = 0; i < 8; i++)
        begin
            dw.digest = chain[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            digest_q = {digest_q, dw};
        end
        restart_msg();
    endtask

    // Drive one word and hold it until accepted; valid stays up for the caller.
    task automatic send_word(logic [7:0] b, logic present, logic eom);
        while (!idle_off && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
        predict_digest(b, present, eom);
        inputs_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(int len, int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                1: b = 8'h00;
                2: b = 8'hff;
                default: b = 8'($urandom);
            endcase
            send_word(b, 1'b1, (i == len - 1));
            // occasional noise word with no byte and no end
            if ($urandom_range(49) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(negedge clk);
    endtask

    // Output side: random stall, compare each accepted word.
    initial begin
        digest_word_t dw;
        logic [255:0] full;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_stall <= hold_rx || (!idle_off && $urandom_range(99) < 24);
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d", digest_word, word_index);
                end
                else
                begin
                    dw = digest_q.pop_front();
                    if (digest_word !== dw.digest || word_index !== dw.index ||
                        final_word !== dw.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     dw.digest, dw.index, dw.last,
                                     digest_word, word_index, final_word);
                    end
                    full = {full[223:0], digest_word};
                    if (final_word === 1'b1 && typed_digest_q.size() != 0 &&
                        dw.last)
                    begin
                        if (full !== typed_digest_q[0] && typed_digest_q[0] !== '0)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("known digest mismatch: exp %h got %h",
                                         typed_digest_q[0], full);
                        end
                        void'(typed_digest_q.pop_front());
                    end
                end
            end
        end
    end

    // Directed rows; known digests for empty message and "abc".
    stim_row_t dir_rows[] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1,
          256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, 1'b0, '0},
        '{8'h63, 1'b1, 1'b1, 1'b1,
          256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
        '{8'h5a, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{8'hff, 1'b1, 1'b0, 1'b0, '0},
        '{8'h3c, 1'b0, 1'b1, 1'b0, '0}
    };

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        restart_msg();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; typed digests ride along in order of message ends
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].eom)
                typed_digest_q = {typed_digest_q,
                                  dir_rows[r].has_exp ? dir_rows[r].exp_digest : 256'h0};
            send_word(dir_rows[r].byte_val, dir_rows[r].present, dir_rows[r].eom);
        end
        // lengths around the padding boundaries: 55, 56, 63, 64 bytes
        send_message(55, 1);
        send_message(56, 2);
        send_message(63, 0);
        send_message(64, 0);
        // sender pauses until all digests are out
        wait_drained();

        // receiver holds off for a long stretch while the sender keeps going
        fork
        begin
            hold_rx = 1'b1;
            repeat (400) @(posedge clk);
            hold_rx = 1'b0;
        end
        begin
            for (int m = 0; m < 4; m++)
                send_message($urandom_range(1, 3), 0);
            in_valid <= 1'b0;
        end
        join
        @(negedge clk);

        // random messages, mostly short, a stretch with idling off
        while (inputs_sent < 470)
        begin
            idle_off = (inputs_sent > 330 && inputs_sent < 410);
            if ($urandom_range(9) == 0)
                send_word(8'($urandom), 1'b0, 1'b1);
            else
                send_message($urandom_range(9) == 0 ? $urandom_range(57, 130)
                                                     : $urandom_range(1, 20), 0);
        end
        idle_off = 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && !timed_out)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5ms;
        timed_out = 1'b1;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
